@@ design/plane_point_signed_distance_unit_defines.svh @@
// ----------------------------------------------------------------------------
// plane_point_signed_distance_unit_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef PLANE_POINT_SIGNED_DISTANCE_UNIT_DEFINES_SVH
`define PLANE_POINT_SIGNED_DISTANCE_UNIT_DEFINES_SVH

// consequent must hold in the cycle of the antecedent
`define PPSD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppsd implication failed");

// expression must never be true outside reset
`define PPSD_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("ppsd forbidden condition seen");

`endif

@@ design/ppsd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppsd_pkg
// Widths and shared types of the point to plane distance pipeline.
// ----------------------------------------------------------------------------
package ppsd_pkg;
   localparam int CW         = 16;          // coordinate width
   localparam int DW         = CW + 1;      // coordinate difference
   localparam int NW         = 2 * DW;      // cross product term and normal
   localparam int DTW        = NW + DW;     // one dot product term
   localparam int SUMW       = DTW + 2;     // sum of three terms
   localparam int MW         = SUMW - 1;    // magnitude of numerator
   localparam int HW         = MW / 2;      // numerator split point
   localparam int NHW        = NW / 2;      // normal split point
   localparam int QW         = 18;          // distance width
   localparam int OW         = 51;          // plane offset width
   localparam int BW         = 16;          // band thickness width
   localparam int SW         = 108;         // square root datapath
   localparam int ROOT_STEPS = QW;
   localparam logic [QW-1:0] QMAX = QW'((1 << (QW - 1)) - 1);

   typedef struct packed {
      logic                 valid;
      logic                 neg;
      logic signed [NW-1:0] na;
      logic signed [NW-1:0] nb;
      logic signed [NW-1:0] nc;
      logic signed [OW-1:0] off;
   } meta_type;
endpackage

@@ design/ppsd_front.sv @@
// ----------------------------------------------------------------------------
// ppsd_front
// Normal, offset, numerator and the two squares over seven register stages.
// ----------------------------------------------------------------------------
module ppsd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [ppsd_pkg::CW-1:0]  ax,
   input  logic signed [ppsd_pkg::CW-1:0]  ay,
   input  logic signed [ppsd_pkg::CW-1:0]  az,
   input  logic signed [ppsd_pkg::CW-1:0]  bx,
   input  logic signed [ppsd_pkg::CW-1:0]  by,
   input  logic signed [ppsd_pkg::CW-1:0]  bz,
   input  logic signed [ppsd_pkg::CW-1:0]  cx,
   input  logic signed [ppsd_pkg::CW-1:0]  cy,
   input  logic signed [ppsd_pkg::CW-1:0]  cz,
   input  logic signed [ppsd_pkg::CW-1:0]  px,
   input  logic signed [ppsd_pkg::CW-1:0]  py,
   input  logic signed [ppsd_pkg::CW-1:0]  pz,
   output ppsd_pkg::meta_type              meta,
   output logic [ppsd_pkg::SW-1:0]         nsq,
   output logic [ppsd_pkg::SW-1:0]         numsq
);
   localparam int DW   = ppsd_pkg::DW;
   localparam int NW   = ppsd_pkg::NW;
   localparam int DTW  = ppsd_pkg::DTW;
   localparam int SUMW = ppsd_pkg::SUMW;
   localparam int MW   = ppsd_pkg::MW;
   localparam int HW   = ppsd_pkg::HW;
   localparam int NHW  = ppsd_pkg::NHW;
   localparam int OW   = ppsd_pkg::OW;
   localparam int SW   = ppsd_pkg::SW;

   // stage 1: differences
   logic                 v1_ff;
   logic signed [DW-1:0] u_ff [3], v_ff [3], w1_ff [3], a1_ff [3];
   logic signed [DW-1:0] u_in [3], v_in [3], w_in [3], a_in [3];

   always_comb begin
      a_in[0] = DW'(ax);  a_in[1] = DW'(ay);  a_in[2] = DW'(az);
      u_in[0] = DW'(bx) - DW'(ax);
      u_in[1] = DW'(by) - DW'(ay);
      u_in[2] = DW'(bz) - DW'(az);
      v_in[0] = DW'(cx) - DW'(ax);
      v_in[1] = DW'(cy) - DW'(ay);
      v_in[2] = DW'(cz) - DW'(az);
      w_in[0] = DW'(px) - DW'(ax);
      w_in[1] = DW'(py) - DW'(ay);
      w_in[2] = DW'(pz) - DW'(az);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      u_ff  <= u_in;
      v_ff  <= v_in;
      w1_ff <= w_in;
      a1_ff <= a_in;
   end

   // stage 2: cross product terms
   logic                 v2_ff;
   logic signed [NW-1:0] pr_ff [6];
   logic signed [NW-1:0] pr_in [6];
   logic signed [DW-1:0] w2_ff [3], a2_ff [3];

   always_comb begin
      pr_in[0] = NW'(u_ff[1] * v_ff[2]);
      pr_in[1] = NW'(v_ff[1] * u_ff[2]);
      pr_in[2] = NW'(u_ff[2] * v_ff[0]);
      pr_in[3] = NW'(v_ff[2] * u_ff[0]);
      pr_in[4] = NW'(u_ff[0] * v_ff[1]);
      pr_in[5] = NW'(v_ff[0] * u_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      pr_ff <= pr_in;
      w2_ff <= w1_ff;
      a2_ff <= a1_ff;
   end

   // stage 3: normal
   logic                 v3_ff;
   logic signed [NW-1:0] n3_ff [3];
   logic signed [NW-1:0] n3_in [3];
   logic signed [DW-1:0] w3_ff [3], a3_ff [3];

   always_comb begin
      n3_in[0] = pr_ff[0] - pr_ff[1];
      n3_in[1] = pr_ff[2] - pr_ff[3];
      n3_in[2] = pr_ff[4] - pr_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      n3_ff <= n3_in;
      w3_ff <= w2_ff;
      a3_ff <= a2_ff;
   end

   // stage 4: dot product terms
   logic                  v4_ff;
   logic signed [DTW-1:0] da_ff [3], dw_ff [3];
   logic signed [DTW-1:0] da_in [3], dw_in [3];
   logic signed [NW-1:0]  n4_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         da_in[i] = DTW'(n3_ff[i] * a3_ff[i]);
         dw_in[i] = DTW'(n3_ff[i] * w3_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      da_ff <= da_in;
      dw_ff <= dw_in;
      n4_ff <= n3_ff;
   end

   // stage 5: sums and magnitudes
   ppsd_pkg::meta_type m5_ff, m5_in;
   logic [MW-1:0]       mn5_ff, mn5_in;
   logic [NW-1:0]       mg5_ff [3], mg5_in [3];
   logic signed [SUMW-1:0] num_c, offs_c;

   always_comb begin
      num_c  = SUMW'(dw_ff[0]) + SUMW'(dw_ff[1]) + SUMW'(dw_ff[2]);
      offs_c = -(SUMW'(da_ff[0]) + SUMW'(da_ff[1]) + SUMW'(da_ff[2]));
      m5_in.valid = v4_ff;
      m5_in.neg   = num_c[SUMW-1];
      m5_in.na    = n4_ff[0];
      m5_in.nb    = n4_ff[1];
      m5_in.nc    = n4_ff[2];
      m5_in.off   = offs_c[OW-1:0];
      mn5_in = num_c[SUMW-1] ? MW'(-num_c) : MW'(num_c);
      for (int i = 0; i < 3; i++) begin
         mg5_in[i] = n4_ff[i][NW-1] ? NW'(-n4_ff[i]) : NW'(n4_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m5_ff <= '0;
      end else begin
         m5_ff <= m5_in;
      end
      mn5_ff <= mn5_in;
      mg5_ff <= mg5_in;
   end

   // stage 6: partial products of the squares
   ppsd_pkg::meta_type m6_ff;
   logic [2*NHW-1:0] nll_ff [3], nlh_ff [3], nhh_ff [3];
   logic [2*NHW-1:0] nll_in [3], nlh_in [3], nhh_in [3];
   logic [2*HW-1:0]  ull_ff, ulh_ff, uhh_ff, ull_in, ulh_in, uhh_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nll_in[i] = mg5_ff[i][NHW-1:0] * mg5_ff[i][NHW-1:0];
         nlh_in[i] = mg5_ff[i][NHW-1:0] * mg5_ff[i][NW-1:NHW];
         nhh_in[i] = mg5_ff[i][NW-1:NHW] * mg5_ff[i][NW-1:NHW];
      end
      ull_in = mn5_ff[HW-1:0] * mn5_ff[HW-1:0];
      ulh_in = mn5_ff[HW-1:0] * mn5_ff[MW-1:HW];
      uhh_in = mn5_ff[MW-1:HW] * mn5_ff[MW-1:HW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m6_ff <= '0;
      end else begin
         m6_ff <= m5_ff;
      end
      nll_ff <= nll_in;
      nlh_ff <= nlh_in;
      nhh_ff <= nhh_in;
      ull_ff <= ull_in;
      ulh_ff <= ulh_in;
      uhh_ff <= uhh_in;
   end

   // stage 7: assemble squares
   ppsd_pkg::meta_type m7_ff;
   logic [SW-1:0] nsq_ff, nsq_in, numsq_ff, numsq_in;

   always_comb begin
      nsq_in = '0;
      for (int i = 0; i < 3; i++) begin
         nsq_in = nsq_in + (SW'(nhh_ff[i]) << (2 * NHW)) + (SW'(nlh_ff[i]) << (NHW + 1))
                  + SW'(nll_ff[i]);
      end
      numsq_in = (SW'(uhh_ff) << (2 * HW)) + (SW'(ulh_ff) << (HW + 1)) + SW'(ull_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m7_ff <= '0;
      end else begin
         m7_ff <= m6_ff;
      end
      nsq_ff   <= nsq_in;
      numsq_ff <= numsq_in;
   end

   assign meta  = m7_ff;
   assign nsq   = nsq_ff;
   assign numsq = numsq_ff;
endmodule

@@ design/ppsd_root.sv @@
// ----------------------------------------------------------------------------
// ppsd_root
// Pipelined integer root: largest q with q*q*nsq <= numsq, one bit per stage.
// ----------------------------------------------------------------------------
module ppsd_root (
   input  logic                       clock,
   input  logic                       reset,
   input  ppsd_pkg::meta_type         meta_i,
   input  logic [ppsd_pkg::SW-1:0]    nsq_i,
   input  logic [ppsd_pkg::SW-1:0]    numsq_i,
   output ppsd_pkg::meta_type         meta_o,
   output logic [ppsd_pkg::QW-1:0]    q_o,
   output logic                       degen_o
);
   localparam int SW    = ppsd_pkg::SW;
   localparam int QW    = ppsd_pkg::QW;
   localparam int STEPS = ppsd_pkg::ROOT_STEPS;

   // residual, q*nsq, nsq, partial q per stage
   logic [SW-1:0]      r_ff [STEPS], qn_ff [STEPS], ns_ff [STEPS];
   logic [SW-1:0]      r_in [STEPS], qn_in [STEPS];
   logic [QW-1:0]      q_ff [STEPS], q_in [STEPS];
   ppsd_pkg::meta_type m_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam int K = STEPS - 1 - i;
      logic [SW-1:0]      r_src, qn_src, ns_src, term;
      logic [QW-1:0]      q_src;
      ppsd_pkg::meta_type m_src;
      logic               take;

      if (i == 0) begin : g_first
         assign r_src  = numsq_i;
         assign qn_src = '0;
         assign ns_src = nsq_i;
         assign q_src  = '0;
         assign m_src  = meta_i;
      end else begin : g_next
         assign r_src  = r_ff[i-1];
         assign qn_src = qn_ff[i-1];
         assign ns_src = ns_ff[i-1];
         assign q_src  = q_ff[i-1];
         assign m_src  = m_ff[i-1];
      end

      // (q + 2^K)^2 * nsq - q^2 * nsq
      assign term     = (qn_src << (K + 1)) + (ns_src << (2 * K));
      assign take     = (r_src >= term);
      assign r_in[i]  = take ? (r_src - term) : r_src;
      assign qn_in[i] = take ? (qn_src + (ns_src << K)) : qn_src;
      assign q_in[i]  = take ? (q_src | (QW'(1) << K)) : q_src;

      always_ff @(posedge clock) begin
         if (reset) begin
            m_ff[i] <= '0;
         end else begin
            m_ff[i] <= m_src;
         end
         r_ff[i]  <= r_in[i];
         qn_ff[i] <= qn_in[i];
         ns_ff[i] <= ns_src;
         q_ff[i]  <= q_in[i];
      end
   end

   assign meta_o  = m_ff[STEPS-1];
   assign q_o     = q_ff[STEPS-1];
   assign degen_o = (ns_ff[STEPS-1] == '0);
endmodule

@@ design/plane_point_signed_distance_unit.sv @@
// The result strobe is registered after the front stages, the root steps and the output register.
// Throughput: one request per cycle; every stage advances each cycle, nothing stalls.
// busy is never raised; the result strobe cannot be held off by the receiver.
// Synchronous reset clears all valid bits and sets band thickness to 0.
// ----------------------------------------------------------------------------
// plane_point_signed_distance_unit
// Signed distance of a query point to the plane through three points.
// ----------------------------------------------------------------------------
module plane_point_signed_distance_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [ppsd_pkg::CW-1:0]    req_first_x,
   input  logic signed [ppsd_pkg::CW-1:0]    req_first_y,
   input  logic signed [ppsd_pkg::CW-1:0]    req_first_z,
   input  logic signed [ppsd_pkg::CW-1:0]    req_second_x,
   input  logic signed [ppsd_pkg::CW-1:0]    req_second_y,
   input  logic signed [ppsd_pkg::CW-1:0]    req_second_z,
   input  logic signed [ppsd_pkg::CW-1:0]    req_third_x,
   input  logic signed [ppsd_pkg::CW-1:0]    req_third_y,
   input  logic signed [ppsd_pkg::CW-1:0]    req_third_z,
   input  logic signed [ppsd_pkg::CW-1:0]    req_query_x,
   input  logic signed [ppsd_pkg::CW-1:0]    req_query_y,
   input  logic signed [ppsd_pkg::CW-1:0]    req_query_z,
   input  logic                              csr_write_enable,
   input  logic [ppsd_pkg::BW-1:0]           csr_write_data,
   output logic                              rsp_strobe,
   output logic signed [ppsd_pkg::QW-1:0]    rsp_signed_distance,
   output logic                              rsp_within_band,
   output logic                              rsp_degenerate,
   output logic signed [ppsd_pkg::NW-1:0]    rsp_normal_x,
   output logic signed [ppsd_pkg::NW-1:0]    rsp_normal_y,
   output logic signed [ppsd_pkg::NW-1:0]    rsp_normal_z,
   output logic signed [ppsd_pkg::OW-1:0]    rsp_plane_offset
);
   localparam int QW = ppsd_pkg::QW;
   localparam int SW = ppsd_pkg::SW;

   ppsd_pkg::meta_type front_meta, root_meta;
   logic [SW-1:0]      nsq, numsq;
   logic [QW-1:0]      root_q, q_clamp;
   logic               root_degen;
   logic [ppsd_pkg::BW-1:0] band_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= '0;
      end else if (csr_write_enable) begin
         band_ff <= csr_write_data;
      end
   end

   ppsd_front u_front (
      .clock (clock), .reset (reset), .start (start),
      .ax (req_first_x),  .ay (req_first_y),  .az (req_first_z),
      .bx (req_second_x), .by (req_second_y), .bz (req_second_z),
      .cx (req_third_x),  .cy (req_third_y),  .cz (req_third_z),
      .px (req_query_x),  .py (req_query_y),  .pz (req_query_z),
      .meta (front_meta), .nsq (nsq), .numsq (numsq)
   );

   ppsd_root u_root (
      .clock (clock), .reset (reset),
      .meta_i (front_meta), .nsq_i (nsq), .numsq_i (numsq),
      .meta_o (root_meta), .q_o (root_q), .degen_o (root_degen)
   );

   // output register
   logic                 strobe_ff, strobe_in;
   logic signed [QW-1:0] dist_ff, dist_in;
   logic                 band_hit_ff, band_hit_in;
   logic                 degen_ff;

   always_comb begin
      q_clamp     = (root_q > ppsd_pkg::QMAX) ? ppsd_pkg::QMAX : root_q;
      strobe_in   = root_meta.valid;
      if (root_degen) begin
         dist_in = '0;
      end else if (root_meta.neg) begin
         dist_in = -$signed(q_clamp);
      end else begin
         dist_in = $signed(q_clamp);
      end
      band_hit_in = !root_degen && (q_clamp <= QW'(band_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      dist_ff          <= dist_in;
      band_hit_ff      <= band_hit_in;
      degen_ff         <= root_degen;
      rsp_normal_x     <= root_meta.na;
      rsp_normal_y     <= root_meta.nb;
      rsp_normal_z     <= root_meta.nc;
      rsp_plane_offset <= root_meta.off;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_signed_distance = dist_ff;
   assign rsp_within_band     = band_hit_ff;
   assign rsp_degenerate      = degen_ff;
endmodule

@@ design/ppsd_checker.sv @@
// ----------------------------------------------------------------------------
// ppsd_checker
// Port level checks of the distance unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "plane_point_signed_distance_unit_defines.svh"

module ppsd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              busy,
   input logic                              rsp_strobe,
   input logic signed [ppsd_pkg::QW-1:0]    rsp_signed_distance,
   input logic                              rsp_within_band,
   input logic                              rsp_degenerate,
   input logic signed [ppsd_pkg::NW-1:0]    rsp_normal_x,
   input logic signed [ppsd_pkg::NW-1:0]    rsp_normal_y,
   input logic signed [ppsd_pkg::NW-1:0]    rsp_normal_z
);
   logic degen_shown, dist_cleared, normal_zero;

   assign degen_shown  = rsp_strobe && rsp_degenerate;
   assign dist_cleared = (rsp_signed_distance == '0) && !rsp_within_band;
   assign normal_zero  = (rsp_normal_x == '0) && (rsp_normal_y == '0)
                         && (rsp_normal_z == '0);

   `PPSD_ASSERT_NEVER(a_never_busy, clock, reset, busy)
   `PPSD_ASSERT_IMPLY(a_degen_zero, clock, reset, degen_shown, dist_cleared)
   `PPSD_ASSERT_IMPLY(a_degen_normal, clock, reset, rsp_strobe, rsp_degenerate == normal_zero)
endmodule

bind plane_point_signed_distance_unit ppsd_checker u_ppsd_checker (.*);

@@ bench/plane_point_signed_distance_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_point_signed_distance_unit_tb
// Drives plane and query points into the distance unit and compares every
// result field with an exact integer predictor or a stated table result,
// over several band settings and idle patterns. Directed requests go first.
// ----------------------------------------------------------------------------
module plane_point_signed_distance_unit_tb;
   typedef struct packed {
      logic signed [ppsd_pkg::QW-1:0] distance;
      logic                           in_band;
      logic                           degen;
      logic signed [ppsd_pkg::NW-1:0] nx;
      logic signed [ppsd_pkg::NW-1:0] ny;
      logic signed [ppsd_pkg::NW-1:0] nz;
      logic signed [ppsd_pkg::OW-1:0] off;
   } distance_result_type;

   typedef struct packed {
      logic [11:0][ppsd_pkg::CW-1:0] pts;   // A xyz, B xyz, C xyz, P xyz
      logic                          typed;
      distance_result_type           res;
   } request_type;

   localparam int SETTLE_CYCLES = 40;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [11:0][ppsd_pkg::CW-1:0] pts_drive = '0;
   logic csr_write_enable = 0;
   logic [ppsd_pkg::BW-1:0] csr_write_data = '0;
   logic rsp_strobe, rsp_within_band, rsp_degenerate;
   logic signed [ppsd_pkg::QW-1:0] rsp_signed_distance;
   logic signed [ppsd_pkg::NW-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic signed [ppsd_pkg::OW-1:0] rsp_plane_offset;

   logic                    typed_drive = 0;
   distance_result_type     typed_res = '0;
   distance_result_type     pending_results[$];
   logic [ppsd_pkg::BW-1:0] band_model = '0;
   int                      mismatches = 0;
   int                      idle_pct = 0;
   request_type             directed[$];

   plane_point_signed_distance_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_x(pts_drive[0]), .req_first_y(pts_drive[1]), .req_first_z(pts_drive[2]),
      .req_second_x(pts_drive[3]), .req_second_y(pts_drive[4]),
      .req_second_z(pts_drive[5]),
      .req_third_x(pts_drive[6]), .req_third_y(pts_drive[7]), .req_third_z(pts_drive[8]),
      .req_query_x(pts_drive[9]), .req_query_y(pts_drive[10]),
      .req_query_z(pts_drive[11]),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_strobe(rsp_strobe), .rsp_signed_distance(rsp_signed_distance),
      .rsp_within_band(rsp_within_band), .rsp_degenerate(rsp_degenerate),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_plane_offset(rsp_plane_offset)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic distance_result_type plane_distance(
         logic [11:0][ppsd_pkg::CW-1:0] pts, logic [ppsd_pkg::BW-1:0] band);
      longint p[12];
      longint ux, uy, uz, vx, vy, vz, na, nb, nc, off, num, mn, ma, mb, mc;
      logic [127:0] nsq, numsq, t;
      longint q;
      distance_result_type r;
      for (int i = 0; i < 12; i++) p[i] = longint'($signed(pts[i]));
      ux = p[3] - p[0]; uy = p[4] - p[1]; uz = p[5] - p[2];
      vx = p[6] - p[0]; vy = p[7] - p[1]; vz = p[8] - p[2];
      na = uy * vz - vy * uz;
      nb = uz * vx - vz * ux;
      nc = ux * vy - vx * uy;
      off = -(na * p[0] + nb * p[1] + nc * p[2]);
      num = na * (p[9] - p[0]) + nb * (p[10] - p[1]) + nc * (p[11] - p[2]);
      ma = na < 0 ? -na : na;
      mb = nb < 0 ? -nb : nb;
      mc = nc < 0 ? -nc : nc;
      mn = num < 0 ? -num : num;
      nsq = 128'(ma) * 128'(ma) + 128'(mb) * 128'(mb) + 128'(mc) * 128'(mc);
      numsq = 128'(mn) * 128'(mn);
      r = '0;
      r.degen = (nsq == 0);
      if (!r.degen) begin
         // bitwise integer square root of numsq / nsq
         q = 0;
         for (int b = ppsd_pkg::QW - 1; b >= 0; b--) begin
            t = 128'(q | (longint'(1) << b));
            if (nsq * t * t <= numsq) q = longint'(t);
         end
         if (q > 131071) q = 131071;
         r.distance = ppsd_pkg::QW'(num < 0 ? -q : q);
         r.in_band = (q <= longint'(band));
      end
      r.nx = ppsd_pkg::NW'(na); r.ny = ppsd_pkg::NW'(nb); r.nz = ppsd_pkg::NW'(nc);
      r.off = ppsd_pkg::OW'(off);
      return r;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // accept requests, model register writes, check results
   always @(posedge clock) begin
      distance_result_type e;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               $display("%0t unexpected result: expected none, actual distance %0d",
                        $time, rsp_signed_distance);
               mismatches++;
            end else begin
               e = pending_results.pop_front();
               check_field("signed_distance", e.distance, rsp_signed_distance);
               check_field("within_band", e.in_band, rsp_within_band);
               check_field("degenerate", e.degen, rsp_degenerate);
               check_field("normal_x", e.nx, rsp_normal_x);
               check_field("normal_y", e.ny, rsp_normal_y);
               check_field("normal_z", e.nz, rsp_normal_z);
               check_field("plane_offset", e.off, rsp_plane_offset);
            end
         end
         if (start && !busy)
            pending_results.push_back(typed_drive ? typed_res
                                                  : plane_distance(pts_drive, band_model));
         if (csr_write_enable) band_model = csr_write_data;
      end
   end

   task automatic send(request_type r);
      @(negedge clock);
      // idle each cycle with the phase's probability
      while ($urandom_range(99) < idle_pct) begin
         start = 0;
         @(negedge clock);
      end
      pts_drive = r.pts;
      typed_drive = r.typed;
      typed_res = r.res;
      start = 1;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_band(logic [ppsd_pkg::BW-1:0] value);
      @(negedge clock);
      start = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable = 1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 0;
   endtask

   task automatic add_row(int ax, int ay, int az, int bx, int by, int bz,
                          int cx, int cy, int cz, int px, int py, int pz,
                          logic typed, distance_result_type res);
      request_type r;
      int v[12];
      v = '{ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz};
      for (int i = 0; i < 12; i++) r.pts[i] = ppsd_pkg::CW'(v[i]);
      r.typed = typed;
      r.res = res;
      directed.push_back(r);
   endtask

   function automatic int pick_coord(int lo, int hi);
      return $signed($urandom_range(hi - lo)) + lo;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int v[12];
      int kind, k, s, t;
      kind = $urandom_range(99);
      for (int i = 0; i < 12; i++) v[i] = pick_coord(-32768, 32767);
      if (kind >= 35 && kind < 55) begin
         for (int i = 0; i < 12; i++) v[i] = pick_coord(-60, 60);
      end else if (kind >= 55 && kind < 70) begin
         // collinear plane points
         for (int i = 0; i < 6; i++) v[i] = pick_coord(-1000, 1000);
         k = pick_coord(-3, 3);
         for (int i = 0; i < 3; i++) v[6 + i] = v[i] + k * (v[3 + i] - v[i]);
      end else if (kind >= 70 && kind < 88) begin
         // query point on or near the plane
         for (int i = 0; i < 9; i++) v[i] = pick_coord(-1000, 1000);
         s = pick_coord(-3, 3);
         t = pick_coord(-3, 3);
         for (int i = 0; i < 3; i++)
            v[9 + i] = v[i] + s * (v[3 + i] - v[i]) + t * (v[6 + i] - v[i])
                       + pick_coord(-2, 2);
      end else if (kind >= 88) begin
         for (int i = 0; i < 12; i++)
            case ($urandom_range(4))
               0: v[i] = -32768;
               1: v[i] = 32767;
               2: v[i] = 0;
               3: v[i] = -1;
               default: v[i] = pick_coord(-32768, 32767);
            endcase
      end
      for (int i = 0; i < 12; i++) r.pts[i] = ppsd_pkg::CW'(v[i]);
      r.typed = 0;
      r.res = '0;
      return r;
   endfunction

   initial begin
      distance_result_type d0, up5, dn5, onp;
      logic [ppsd_pkg::BW-1:0] bands[4];
      int pcts[4];
      d0 = '0; d0.degen = 1;
      up5 = '0; up5.distance = 5; up5.nz = 1;
      dn5 = up5; dn5.distance = -5;
      onp = '0; onp.in_band = 1; onp.nz = 1;
      add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, d0);
      add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
              -32768, -32768, -32768, 1, d0);
      add_row(1, 2, 3, 2, 4, 6, 3, 6, 9, 100, -100, 5, 1, d0);
      add_row(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 5, 1, up5);
      add_row(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, -5, 1, dn5);
      add_row(0, 0, 0, 1, 0, 0, 0, 1, 0, 7, 9, 0, 1, onp);
      add_row(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768,
              32767, 32767, 32767, 0, '0);
      add_row(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768,
              -32768, -32768, 32767, 0, '0);
      add_row(32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767,
              -32768, -32768, -32768, 0, '0);
      add_row(-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767,
              32767, 32767, -32768, 0, '0);
      add_row(-1, -1, -1, 0, 0, 0, 1, 0, 0, -1, 1, -1, 0, '0);
      add_row(3, 4, 5, 7, -2, 9, -6, 8, 1, 12, 13, -14, 0, '0);
      add_row(0, 0, 0, 3, 0, 0, 0, 3, 0, 1, 1, 1, 0, '0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (directed[i]) send(directed[i]);

      bands = '{16'd0, 16'hFFFF, ppsd_pkg::BW'($urandom),
                ppsd_pkg::BW'($urandom_range(200))};
      pcts = '{0, 54, 54, 31};
      for (int ph = 0; ph < 4; ph++) begin
         write_band(bands[ph]);
         idle_pct = pcts[ph];
         for (int n = 0; n < 185; n++) send(random_request());
      end

      @(negedge clock);
      start = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2ms;
      $display("Mismatches found");
      $finish;
   end
endmodule
